// File: hw/rtl/acs_pkg.sv
package acs_pkg;

    localparam int AVERAGE_TAPS = 7;

    localparam int SWING_W  = 17;
    localparam int SUM_W    = SWING_W + $clog2(AVERAGE_TAPS + 1);
    localparam int DIV_L    = $clog2(AVERAGE_TAPS);
    localparam int DIV_S    = SUM_W + DIV_L;
    localparam int DIV_M_W  = DIV_S + 1;
    localparam int PROD_W   = SUM_W + DIV_M_W;
    localparam int DIFF_W   = 35;
    localparam int MINPP_W  = 11;

    // ceil(2^DIV_S / AVERAGE_TAPS): exact quotient for every sum below 2^SUM_W
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(
        ((64'd1 << DIV_S) + 64'(AVERAGE_TAPS) - 64'd1) / 64'(AVERAGE_TAPS));

    localparam logic [SWING_W-1:0] SWING_MAX   = '1;
    localparam logic [SWING_W-1:0] DEAD_BAND   = SWING_W'(200);
    localparam logic [SWING_W-1:0] SHOCK_LEVEL = SWING_W'(700);
    localparam logic [MINPP_W-1:0] PP_BASE     = MINPP_W'(80);
    localparam logic [1:0]         SHOCK_SAMPLES = 2'd3;

    localparam logic [31:0] DEBOUNCE_MS    = 32'd300;
    localparam logic [31:0] CAD_MIN_MS     = 32'd250;
    localparam logic [31:0] CAD_MAX_MS     = 32'd1200;
    localparam logic [31:0] CAD_TIMEOUT_MS = 32'd2500;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_GRAVITY_X  = 3'd0,
        REG_GRAVITY_Y  = 3'd1,
        REG_GRAVITY_Z  = 3'd2,
        REG_REST_PROJ  = 3'd3,
        REG_BREED      = 3'd4
    } reg_index_t;

    localparam logic signed [15:0] GRAVITY_X_RST = 16'sd0;
    localparam logic signed [15:0] GRAVITY_Y_RST = 16'sd0;
    localparam logic signed [15:0] GRAVITY_Z_RST = 16'sd16384;
    localparam logic signed [16:0] REST_PROJ_RST = 17'sd0;
    localparam logic [3:0]         BREED_RST     = 4'd4;

    typedef logic signed [15:0]    accel_t;
    typedef logic [31:0]           time_t;
    typedef logic [SWING_W-1:0]    swing_t;
    typedef logic [SUM_W-1:0]      swing_sum_t;

endpackage

// File: hw/rtl/acs_if.sv
interface acs_sample_if;
    logic            valid;
    logic            ready;
    acs_pkg::accel_t accel_x;
    acs_pkg::accel_t accel_y;
    acs_pkg::accel_t accel_z;
    acs_pkg::time_t  time_ms;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface acs_result_if;
    logic            valid;
    logic            ready;
    logic [31:0]     step_count;
    logic [1:0]      steps_added;
    acs_pkg::swing_t filtered_swing;
    logic            cadence_active;
    logic            sample_ignored;

    modport source (output valid, step_count, steps_added, filtered_swing,
                    cadence_active, sample_ignored, input ready);
    modport sink   (input valid, step_count, steps_added, filtered_swing,
                    cadence_active, sample_ignored, output ready);
endinterface

// File: hw/rtl/accel_step_counter_unit.sv
// Channel   Dir  Role    Word
// sample    in   sink    accel_x/y/z, time_ms
// result    out  source  step_count, steps_added, filtered_swing, cadence_active,
//                        sample_ignored
// apb       in   slave   gravity_x/y/z, rest_projection, breed_factor
//
// Six register stages: input, gravity products, swing, shock/average sum,
// divide by tap count, peak/valley/cadence plus result word.
// One word per cycle sustained while result.ready is held high.
// rst_n clears all control and step state; the tap history resets to zero.
// Each stage holds while the one after it is full and stalled; a stage that
// is empty or moving keeps taking words, so bubbles are absorbed.
module accel_step_counter_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [acs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    acs_sample_if.sink                 sample,
    acs_result_if.source               result
);

    // configuration
    logic signed [15:0] gravity_x_reg, gravity_y_reg, gravity_z_reg;
    logic signed [16:0] rest_proj_reg;
    logic [3:0]         breed_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[acs_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_x_reg <= acs_pkg::GRAVITY_X_RST;
            gravity_y_reg <= acs_pkg::GRAVITY_Y_RST;
            gravity_z_reg <= acs_pkg::GRAVITY_Z_RST;
            rest_proj_reg <= acs_pkg::REST_PROJ_RST;
            breed_reg     <= acs_pkg::BREED_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                acs_pkg::REG_GRAVITY_X: gravity_x_reg <= pwdata[15:0];
                acs_pkg::REG_GRAVITY_Y: gravity_y_reg <= pwdata[15:0];
                acs_pkg::REG_GRAVITY_Z: gravity_z_reg <= pwdata[15:0];
                acs_pkg::REG_REST_PROJ: rest_proj_reg <= pwdata[16:0];
                acs_pkg::REG_BREED:     breed_reg     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            acs_pkg::REG_GRAVITY_X: prdata = 32'(gravity_x_reg);
            acs_pkg::REG_GRAVITY_Y: prdata = 32'(gravity_y_reg);
            acs_pkg::REG_GRAVITY_Z: prdata = 32'(gravity_z_reg);
            acs_pkg::REG_REST_PROJ: prdata = 32'(rest_proj_reg);
            acs_pkg::REG_BREED:     prdata = {28'd0, breed_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // pipeline flow
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || result.ready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign sample.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= sample.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // stage 1: input word
    acs_pkg::accel_t ax1_reg, ay1_reg, az1_reg;
    acs_pkg::time_t  t1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample.valid)
        begin
            ax1_reg <= sample.accel_x;
            ay1_reg <= sample.accel_y;
            az1_reg <= sample.accel_z;
            t1_reg  <= sample.time_ms;
        end
    end

    // stage 2: products
    logic signed [31:0] px2_reg, py2_reg, pz2_reg;
    acs_pkg::time_t     t2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            px2_reg <= 32'(ax1_reg) * 32'(gravity_x_reg);
            py2_reg <= 32'(ay1_reg) * 32'(gravity_y_reg);
            pz2_reg <= 32'(az1_reg) * 32'(gravity_z_reg);
            t2_reg  <= t1_reg;
        end
    end

    // stage 3: rounded absolute swing
    logic signed [acs_pkg::DIFF_W-1:0] diff3;
    logic [acs_pkg::DIFF_W-1:0]        mag3;
    logic [acs_pkg::DIFF_W-1:0]        rnd_sum3;
    logic [acs_pkg::DIFF_W-15:0]       rnd3;
    acs_pkg::swing_t                   swing3_next;
    acs_pkg::swing_t                   swing3_reg;
    acs_pkg::time_t                    t3_reg;

    assign diff3 = acs_pkg::DIFF_W'(px2_reg) + acs_pkg::DIFF_W'(py2_reg)
                 + acs_pkg::DIFF_W'(pz2_reg)
                 - (acs_pkg::DIFF_W'(rest_proj_reg) <<< 14);
    assign mag3 = diff3[acs_pkg::DIFF_W-1] ? acs_pkg::DIFF_W'(-diff3)
                                            : acs_pkg::DIFF_W'(diff3);
    assign rnd_sum3 = mag3 + acs_pkg::DIFF_W'(8192);
    assign rnd3 = rnd_sum3[acs_pkg::DIFF_W-1:14];
    assign swing3_next = (rnd3 > ($bits(rnd3))'(acs_pkg::SWING_MAX))
                       ? acs_pkg::SWING_MAX : rnd3[acs_pkg::SWING_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            swing3_reg <= swing3_next;
            t3_reg     <= t2_reg;
        end
    end

    // stage 4: shock hold-off, dead band, tap history and running sum
    logic                 ld4;
    logic                 shock4;
    acs_pkg::swing_t      db4;
    acs_pkg::swing_t      prev_swing_reg, prev_swing_next;
    logic [1:0]           shock_hold_reg, shock_hold_next;
    acs_pkg::swing_t      taps_reg [acs_pkg::AVERAGE_TAPS];
    acs_pkg::swing_sum_t  sum_reg, sum_next;
    logic                 ign4_reg;
    acs_pkg::swing_sum_t  sum4_reg;
    acs_pkg::time_t       t4_reg;

    assign ld4    = rdy4 && v3_reg;
    assign shock4 = (shock_hold_reg != 2'd0)
                 || (prev_swing_reg < acs_pkg::DEAD_BAND
                     && swing3_reg >= acs_pkg::SHOCK_LEVEL);
    assign db4    = (swing3_reg < acs_pkg::DEAD_BAND) ? '0 : swing3_reg;

    always_comb
    begin
        shock_hold_next = shock_hold_reg;
        prev_swing_next = prev_swing_reg;
        sum_next        = sum_reg;
        if (ld4)
        begin
            if (shock4)
            begin
                shock_hold_next = (shock_hold_reg != 2'd0) ? shock_hold_reg - 2'd1
                                                           : acs_pkg::SHOCK_SAMPLES;
                prev_swing_next = swing3_reg;
            end
            else
            begin
                prev_swing_next = db4;
                sum_next = sum_reg + acs_pkg::SUM_W'(db4)
                         - acs_pkg::SUM_W'(taps_reg[acs_pkg::AVERAGE_TAPS-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shock_hold_reg <= 2'd0;
            prev_swing_reg <= '0;
            sum_reg        <= '0;
            for (int i = 0; i < acs_pkg::AVERAGE_TAPS; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else
        begin
            shock_hold_reg <= shock_hold_next;
            prev_swing_reg <= prev_swing_next;
            sum_reg        <= sum_next;
            if (ld4 && !shock4)
            begin
                taps_reg[0] <= db4;
                for (int i = 1; i < acs_pkg::AVERAGE_TAPS; i++)
                begin
                    taps_reg[i] <= taps_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            ign4_reg <= shock4;
            sum4_reg <= sum_next;
            t4_reg   <= t3_reg;
        end
    end

    // stage 5: average by reciprocal multiply
    logic [acs_pkg::PROD_W-1:0] prod5;
    logic                       ign5_reg;
    acs_pkg::swing_t            cur5_reg;
    acs_pkg::time_t             t5_reg;

    assign prod5 = acs_pkg::PROD_W'(sum4_reg) * acs_pkg::PROD_W'(acs_pkg::DIV_M);

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            ign5_reg <= ign4_reg;
            cur5_reg <= prod5[acs_pkg::DIV_S +: acs_pkg::SWING_W];
            t5_reg   <= t4_reg;
        end
    end

    // stage 6: peak/valley tracking, cadence gate, result word
    logic                        ld6;
    logic [acs_pkg::MINPP_W-1:0] min_pp;
    logic                        dir_unk_reg, dir_unk_next;
    logic                        rising_reg, rising_next;
    logic                        armed_reg, armed_next;
    acs_pkg::swing_t             peak_reg, peak_next;
    acs_pkg::swing_t             valley_reg, valley_next;
    logic                        pend_reg, pend_next;
    acs_pkg::time_t              pend_time_reg, pend_time_next;
    logic                        incad_reg, incad_next;
    acs_pkg::time_t              last_time_reg, last_time_next;
    logic [31:0]                 total_reg, total_next;
    logic [1:0]                  added;
    logic signed [acs_pkg::SWING_W:0] drop6, rise6;
    acs_pkg::time_t              dt_last6, dt_pend6;

    assign ld6      = rdy6 && v5_reg;
    assign min_pp   = acs_pkg::MINPP_W'(breed_reg) * acs_pkg::PP_BASE;
    assign dt_last6 = t5_reg - last_time_reg;
    assign dt_pend6 = t5_reg - pend_time_reg;

    always_comb
    begin
        dir_unk_next   = dir_unk_reg;
        rising_next    = rising_reg;
        armed_next     = armed_reg;
        peak_next      = peak_reg;
        valley_next    = valley_reg;
        pend_next      = pend_reg;
        pend_time_next = pend_time_reg;
        incad_next     = incad_reg;
        last_time_next = last_time_reg;
        total_next     = total_reg;
        added          = 2'd0;
        drop6          = '0;
        rise6          = '0;
        if (ld6 && !ign5_reg)
        begin
            if (incad_reg && dt_last6 > acs_pkg::CAD_TIMEOUT_MS)
            begin
                incad_next = 1'b0;
                pend_next  = 1'b0;
            end
            if (dir_unk_reg)
            begin
                peak_next    = cur5_reg;
                valley_next  = cur5_reg;
                dir_unk_next = 1'b0;
                rising_next  = 1'b1;
            end
            drop6 = (acs_pkg::SWING_W + 1)'(peak_next) - (acs_pkg::SWING_W + 1)'(cur5_reg);
            rise6 = (acs_pkg::SWING_W + 1)'(cur5_reg) - (acs_pkg::SWING_W + 1)'(valley_next);
            if (rising_next)
            begin
                if (cur5_reg > peak_next)
                begin
                    peak_next = cur5_reg;
                end
                else if (drop6 > $signed((acs_pkg::SWING_W + 1)'(min_pp)))
                begin
                    rising_next = 1'b0;
                    armed_next  = 1'b1;
                    valley_next = cur5_reg;
                end
            end
            else
            begin
                if (cur5_reg < valley_next)
                begin
                    valley_next = cur5_reg;
                end
                else if (armed_next && rise6 > $signed((acs_pkg::SWING_W + 1)'(min_pp)))
                begin
                    if (dt_last6 >= acs_pkg::DEBOUNCE_MS)
                    begin
                        if (incad_next)
                        begin
                            if (dt_last6 >= acs_pkg::CAD_MIN_MS
                                && dt_last6 <= acs_pkg::CAD_MAX_MS)
                            begin
                                last_time_next = t5_reg;
                                added          = 2'd1;
                            end
                            else
                            begin
                                incad_next     = 1'b0;
                                pend_next      = 1'b1;
                                pend_time_next = t5_reg;
                            end
                        end
                        else if (pend_next)
                        begin
                            if (dt_pend6 >= acs_pkg::CAD_MIN_MS
                                && dt_pend6 <= acs_pkg::CAD_MAX_MS)
                            begin
                                last_time_next = t5_reg;
                                pend_next      = 1'b0;
                                incad_next     = 1'b1;
                                added          = 2'd2;
                            end
                            else if (dt_pend6 > acs_pkg::CAD_MAX_MS)
                            begin
                                pend_time_next = t5_reg;
                            end
                        end
                        else
                        begin
                            pend_next      = 1'b1;
                            pend_time_next = t5_reg;
                        end
                    end
                    armed_next  = 1'b0;
                    rising_next = 1'b1;
                    peak_next   = cur5_reg;
                    valley_next = cur5_reg;
                end
            end
            total_next = total_reg + 32'(added);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_unk_reg   <= 1'b1;
            rising_reg    <= 1'b1;
            armed_reg     <= 1'b0;
            peak_reg      <= '0;
            valley_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_time_reg <= '0;
            incad_reg     <= 1'b0;
            last_time_reg <= '0;
            total_reg     <= '0;
        end
        else
        begin
            dir_unk_reg   <= dir_unk_next;
            rising_reg    <= rising_next;
            armed_reg     <= armed_next;
            peak_reg      <= peak_next;
            valley_reg    <= valley_next;
            pend_reg      <= pend_next;
            pend_time_reg <= pend_time_next;
            incad_reg     <= incad_next;
            last_time_reg <= last_time_next;
            total_reg     <= total_next;
        end
    end

    logic [31:0]     count_reg;
    logic [1:0]      added_reg;
    acs_pkg::swing_t filt_reg;
    logic            cad_reg;
    logic            ign_reg;

    always_ff @(posedge clk)
    begin
        if (ld6)
        begin
            count_reg <= total_next;
            added_reg <= added;
            filt_reg  <= ign5_reg ? '0 : cur5_reg;
            cad_reg   <= incad_next;
            ign_reg   <= ign5_reg;
        end
    end

    assign result.valid          = v6_reg;
    assign result.step_count     = count_reg;
    assign result.steps_added    = added_reg;
    assign result.filtered_swing = filt_reg;
    assign result.cadence_active = cad_reg;
    assign result.sample_ignored = ign_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 40;

    localparam int SWING_CEILING    = 131071;
    localparam int DEAD_BAND_COUNTS = 200;
    localparam int SHOCK_COUNTS     = 700;
    localparam int PEAK_BASE        = 80;

    localparam logic [1:0] SHOCK_HOLD_SAMPLES = 2'd3;

    localparam acs_pkg::time_t DEBOUNCE_GAP_MS = 32'd300;
    localparam acs_pkg::time_t STRIDE_MIN_MS   = 32'd250;
    localparam acs_pkg::time_t STRIDE_MAX_MS   = 32'd1200;
    localparam acs_pkg::time_t STRIDE_IDLE_MS  = 32'd2500;

    typedef struct packed {
        acs_pkg::accel_t ax;
        acs_pkg::accel_t ay;
        acs_pkg::accel_t az;
        acs_pkg::time_t  stamp;
    } sample_word_t;

    typedef struct packed {
        logic [31:0]     step_count;
        logic [1:0]      steps_added;
        acs_pkg::swing_t filtered_swing;
        logic            cadence_active;
        logic            sample_ignored;
    } report_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [acs_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    acs_sample_if sample_ch();
    acs_result_if result_ch();

    accel_step_counter_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    // register copy
    acs_pkg::accel_t     grav_x;
    acs_pkg::accel_t     grav_y;
    acs_pkg::accel_t     grav_z;
    logic signed [16:0]  rest_counts;
    logic [3:0]          breed;

    // pedometer state
    acs_pkg::swing_t tap_store [acs_pkg::AVERAGE_TAPS];
    int              tap_next;
    logic            level_unknown;
    logic            climbing;
    logic            armed;
    int              peak_hold;
    int              valley_hold;
    int              last_swing;
    logic            step_waiting;
    acs_pkg::time_t  waiting_since;
    logic            walking;
    acs_pkg::time_t  last_step_ms;
    logic [1:0]      shock_left;
    logic [31:0]     total_steps;

    sample_word_t sample_queue[$];
    report_t      expected_reports[$];

    acs_pkg::time_t walk_time;
    int    send_wait;
    int    send_burst;
    int    recv_wait;
    int    recv_burst;
    int    hold_off;
    int    reports_seen;
    int    fail_count;
    int    idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void pedometer_step(input acs_pkg::accel_t ax,
                                           input acs_pkg::accel_t ay,
                                           input acs_pkg::accel_t az,
                                           input acs_pkg::time_t now);
        longint         proj;
        longint         dev;
        longint         rounded;
        int             swing;
        int             tap_sum;
        int             level;
        int             min_swing;
        logic [1:0]     added;
        acs_pkg::time_t gap;
        proj = longint'(ax) * longint'(grav_x) + longint'(ay) * longint'(grav_y)
             + longint'(az) * longint'(grav_z);
        dev = proj - longint'(rest_counts) * 16384;
        if (dev < 0)
            dev = -dev;
        rounded = (dev + 8192) >>> 14;
        swing = (rounded > SWING_CEILING) ? SWING_CEILING : int'(rounded);
        added = 2'd0;

        if (shock_left != 2'd0 || (last_swing < DEAD_BAND_COUNTS && swing >= SHOCK_COUNTS))
        begin
            if (shock_left != 2'd0)
                shock_left = shock_left - 2'd1;
            else
                shock_left = SHOCK_HOLD_SAMPLES;
            last_swing = swing;
            expected_reports.push_back('{total_steps, 2'd0, 17'd0, walking, 1'b1});
            return;
        end

        if (swing < DEAD_BAND_COUNTS)
            swing = 0;
        tap_store[tap_next] = acs_pkg::swing_t'(swing);
        tap_next = (tap_next + 1) % acs_pkg::AVERAGE_TAPS;
        tap_sum = 0;
        for (int i = 0; i < acs_pkg::AVERAGE_TAPS; i++)
            tap_sum += int'(tap_store[i]);
        level = tap_sum / acs_pkg::AVERAGE_TAPS;

        if (walking && acs_pkg::time_t'(now - last_step_ms) > STRIDE_IDLE_MS)
        begin
            walking = 1'b0;
            step_waiting = 1'b0;
        end

        min_swing = PEAK_BASE * int'(breed);

        if (level_unknown)
        begin
            peak_hold = level;
            valley_hold = level;
            level_unknown = 1'b0;
            climbing = 1'b1;
        end

        if (climbing)
        begin
            if (level > peak_hold)
                peak_hold = level;
            else if (peak_hold - level > min_swing)
            begin
                climbing = 1'b0;
                armed = 1'b1;
                valley_hold = level;
            end
        end
        else
        begin
            if (level < valley_hold)
                valley_hold = level;
            else if (armed && level - valley_hold > min_swing)
            begin
                if (acs_pkg::time_t'(now - last_step_ms) >= DEBOUNCE_GAP_MS)
                begin
                    if (walking)
                    begin
                        gap = now - last_step_ms;
                        if (gap >= STRIDE_MIN_MS && gap <= STRIDE_MAX_MS)
                        begin
                            last_step_ms = now;
                            added = 2'd1;
                        end
                        else
                        begin
                            walking = 1'b0;
                            step_waiting = 1'b1;
                            waiting_since = now;
                        end
                    end
                    else if (step_waiting)
                    begin
                        gap = now - waiting_since;
                        if (gap >= STRIDE_MIN_MS && gap <= STRIDE_MAX_MS)
                        begin
                            last_step_ms = now;
                            step_waiting = 1'b0;
                            walking = 1'b1;
                            added = 2'd2;
                        end
                        else if (gap > STRIDE_MAX_MS)
                            waiting_since = now;
                    end
                    else
                    begin
                        step_waiting = 1'b1;
                        waiting_since = now;
                    end
                end
                armed = 1'b0;
                climbing = 1'b1;
                peak_hold = level;
                valley_hold = level;
            end
        end

        total_steps = total_steps + 32'(added);
        last_swing = swing;
        expected_reports.push_back('{total_steps, added, acs_pkg::swing_t'(level),
                                     walking, 1'b0});
    endfunction

    function automatic acs_pkg::accel_t scale_axis(input acs_pkg::accel_t g,
                                                   input int level);
        longint v;
        v = (longint'(g) * level) >>> 14;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return acs_pkg::accel_t'(v);
    endfunction

    function automatic sample_word_t along_gravity(input int level,
                                                   input acs_pkg::time_t stamp);
        sample_word_t w;
        w.ax = scale_axis(grav_x, level);
        w.ay = scale_axis(grav_y, level);
        w.az = scale_axis(grav_z, level);
        w.stamp = stamp;
        return w;
    endfunction

    function automatic sample_word_t noise_word();
        sample_word_t w;
        if ($urandom_range(0, 3) == 0)
        begin
            w.ax = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            w.ay = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            w.az = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        end
        else
        begin
            w.ax = acs_pkg::accel_t'($urandom);
            w.ay = acs_pkg::accel_t'($urandom);
            w.az = acs_pkg::accel_t'($urandom);
        end
        w.stamp = $urandom_range(0, 1) ? acs_pkg::time_t'($urandom) : walk_time;
        return w;
    endfunction

    // gait bursts: triangle swing along gravity, with pauses, wraps and stray words
    task automatic queue_walk(input int n);
        int           period;
        int           dt;
        int           amp;
        int           pos;
        int           ramp;
        int           sgn;
        int           left;
        sample_word_t w;
        left = 0;
        pos = 0;
        period = 16;
        dt = 40;
        amp = 1000;
        sgn = 1;
        for (int k = 0; k < n; k++)
        begin
            if (left == 0)
            begin
                period = $urandom_range(8, 24);
                dt = $urandom_range(15, 60);
                amp = $urandom_range(300, 3000);
                sgn = $urandom_range(0, 1) ? 1 : -1;
                left = period * $urandom_range(2, 8);
                pos = 0;
                case ($urandom_range(0, 9))
                    0: walk_time = walk_time + $urandom_range(2600, 9000);
                    1: walk_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                    default: ;
                endcase
            end
            if ($urandom_range(0, 19) == 0)
                w = noise_word();
            else
            begin
                ramp = (pos < period / 2) ? 2 * amp * pos / period
                                          : 2 * amp * (period - pos) / period;
                w = along_gravity(int'(rest_counts) + sgn * ramp, walk_time);
            end
            sample_queue.push_back(w);
            walk_time = walk_time + dt + $urandom_range(0, 4);
            pos = (pos + 1) % period;
            left--;
        end
    endtask

    task automatic queue_noise(input int n);
        for (int k = 0; k < n; k++)
        begin
            sample_queue.push_back(noise_word());
            walk_time = walk_time + $urandom_range(10, 100);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (sample_queue.size() != 0 || sample_ch.valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            acs_pkg::REG_GRAVITY_X: grav_x = value[15:0];
            acs_pkg::REG_GRAVITY_Y: grav_y = value[15:0];
            acs_pkg::REG_GRAVITY_Z: grav_z = value[15:0];
            acs_pkg::REG_REST_PROJ: rest_counts = value[16:0];
            acs_pkg::REG_BREED:     breed = value[3:0];
            default: ;
        endcase
    endtask

    task automatic program_phase(input int gx, input int gy, input int gz,
                                 input int rest, input int factor);
        wait_drained();
        reg_write(acs_pkg::REG_GRAVITY_X, 32'(gx));
        reg_write(acs_pkg::REG_GRAVITY_Y, 32'(gy));
        reg_write(acs_pkg::REG_GRAVITY_Z, 32'(gz));
        reg_write(acs_pkg::REG_REST_PROJ, 32'(rest));
        reg_write(acs_pkg::REG_BREED, 32'(factor));
        reg_write(3'(acs_pkg::REG_BREED) + 3'($urandom_range(1, 3)), $urandom);
        @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
                $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_word_t w;
        logic         offer;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.accel_x <= '0;
            sample_ch.accel_y <= '0;
            sample_ch.accel_z <= '0;
            sample_ch.time_ms <= '0;
            send_wait = 0;
            send_burst = 0;
        end
        else
        begin
            offer = sample_ch.valid;
            if (sample_ch.valid && sample_ch.ready)
            begin
                pedometer_step(sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z,
                               sample_ch.time_ms);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (send_wait != 0)
                    send_wait--;
                else if (sample_queue.size() != 0)
                begin
                    w = sample_queue.pop_front();
                    sample_ch.accel_x <= w.ax;
                    sample_ch.accel_y <= w.ay;
                    sample_ch.accel_z <= w.az;
                    sample_ch.time_ms <= w.stamp;
                    offer = 1'b1;
                    if (send_burst != 0)
                    begin
                        send_burst--;
                        send_wait = 0;
                    end
                    else
                    begin
                        send_wait = $urandom_range(0, 8);
                        if ($urandom_range(0, 15) == 0)
                            send_burst = $urandom_range(20, 80);
                    end
                end
            end
            sample_ch.valid <= offer;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : report_monitor
        report_t want;
        logic    take;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_wait = 0;
            recv_burst = 0;
            hold_off = 0;
            reports_seen = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_LIMIT)
                        $error("result word with no sample pending, step_count %0d",
                               result_ch.step_count);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("step_count", want.step_count, result_ch.step_count);
                    check_field("steps_added", 32'(want.steps_added), 32'(result_ch.steps_added));
                    check_field("filtered_swing", 32'(want.filtered_swing),
                                32'(result_ch.filtered_swing));
                    check_field("cadence_active", 32'(want.cadence_active),
                                32'(result_ch.cadence_active));
                    check_field("sample_ignored", 32'(want.sample_ignored),
                                32'(result_ch.sample_ignored));
                end
                // long back-pressure so the pipeline fills and stalls its input
                if (reports_seen % 400 == 150)
                    hold_off = 90;
                else if (recv_burst != 0)
                begin
                    recv_burst--;
                    recv_wait = 0;
                end
                else
                begin
                    recv_wait = $urandom_range(0, 8);
                    if ($urandom_range(0, 15) == 0)
                        recv_burst = $urandom_range(20, 80);
                end
            end
            if (hold_off != 0)
            begin
                hold_off--;
                take = 1'b0;
            end
            else if (recv_wait != 0)
            begin
                recv_wait--;
                take = 1'b0;
            end
            else
                take = 1'b1;
            result_ch.ready <= take;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : run_control
        rst_n = 1'b0;

        grav_x = 16'sd0;
        grav_y = 16'sd0;
        grav_z = 16'sd16384;
        rest_counts = 17'sd0;
        breed = 4'd4;
        foreach (tap_store[i])
            tap_store[i] = '0;
        tap_next = 0;
        level_unknown = 1'b1;
        climbing = 1'b1;
        armed = 1'b0;
        peak_hold = 0;
        valley_hold = 0;
        last_swing = 0;
        step_waiting = 1'b0;
        waiting_since = '0;
        walking = 1'b0;
        last_step_ms = '0;
        shock_left = 2'd0;
        total_steps = '0;
        walk_time = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, shock hold-off, dead band, extreme words
        sample_queue.push_back('{16'h0000, 16'h0000, 16'h0000, 32'd0});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'h7FFF, 32'd40});
        sample_queue.push_back('{16'h8000, 16'h8000, 16'h8000, 32'd80});
        sample_queue.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF});
        sample_queue.push_back('{16'hFFFF, 16'h0001, 16'h0000, 32'd120});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd150, 32'd160});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'h8000, 32'd200});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd100, 32'd240});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd300, 32'd280});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd500, 32'd320});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd900, 32'd360});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd1400, 32'd400});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd1400, 32'd440});
        sample_queue.push_back('{16'h0000, 16'h0000, 16'd0, 32'd480});
        walk_time = 32'd520;
        queue_walk(150);

        program_phase(16384, 0, 0, 0, 1);
        queue_walk(150);
        program_phase(0, -16384, 0, 3000, 10);
        queue_walk(150);
        program_phase(11585, 11585, 0, -2500, 0);
        queue_walk(150);
        program_phase(16384, 16384, 16384, 65535, 15);
        queue_noise(60);
        program_phase(-16384, -16384, -16384, -65536, 4);
        queue_noise(40);
        program_phase(-32768, 32767, 0, $urandom_range(0, 131071) - 65536,
                      $urandom_range(0, 15));
        queue_noise(40);
        program_phase(9459, -9459, 9459, $urandom_range(0, 20000) - 10000,
                      $urandom_range(1, 10));
        queue_walk(150);
        program_phase(0, 0, -16384, 0, 2);
        queue_walk(150);

        wait_drained();
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/acs_pkg.sv
hw/rtl/acs_if.sv
hw/rtl/accel_step_counter_unit.sv
tb/testbench.sv
